[rtl/fern_ifs_step_core_defines.svh]
// Assertion macros shared by the fern IFS step RTL.
`ifndef FERN_IFS_STEP_CORE_DEFINES_SVH
`define FERN_IFS_STEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fifs_pkg.sv]
// Types, constants and coefficient lookup for the fern IFS step core.
package fifs_pkg;

    localparam int SIZE_W = 12;
    localparam int PT_W   = 32;
    localparam int COEF_W = 18;

    localparam logic [SIZE_W-1:0] CANVAS_RESET = 12'd400;

    // Map selection bounds on the 16-bit random fraction
    localparam logic [15:0] THR_STEM = 16'd656;
    localparam logic [15:0] THR_MAIN = 16'd56361;
    localparam logic [15:0] THR_LEFT = 16'd60949;

    // ceil(2^32 / 11); exact floor division for numerators below 2^27
    localparam logic [28:0] RECIP_11 = 29'd390451573;

    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_MAIN  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } t_map;

    typedef struct packed {
        logic        restart;
        logic [15:0] random_fraction;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic        on_canvas;
        logic [1:0]  map_used;
    } t_out_beat;

    // Q16 coefficients: x' = ax*x + bx*y + cx, y' = ay*x + by*y + cy
    typedef struct packed {
        logic signed [COEF_W-1:0] ax;
        logic signed [COEF_W-1:0] bx;
        logic signed [COEF_W-1:0] cx;
        logic signed [COEF_W-1:0] ay;
        logic signed [COEF_W-1:0] by;
        logic signed [COEF_W-1:0] cy;
    } t_coef;

    function automatic t_map pick_map(input logic [15:0] frac);
        t_map m;
        if (frac < THR_STEM) begin
            m = MAP_STEM;
        end else if (frac < THR_MAIN) begin
            m = MAP_MAIN;
        end else if (frac < THR_LEFT) begin
            m = MAP_LEFT;
        end else begin
            m = MAP_RIGHT;
        end
        return m;
    endfunction

    function automatic t_coef map_coef(input t_map m);
        t_coef c;
        unique case (m)
            MAP_STEM: begin
                c.ax = 18'sd0;      c.bx = 18'sd0;      c.cx = 18'sd0;
                c.ay = 18'sd0;      c.by = 18'sd10486;  c.cy = 18'sd0;
            end
            MAP_MAIN: begin
                c.ax = 18'sd55706;  c.bx = 18'sd2621;   c.cx = 18'sd0;
                c.ay = -18'sd2621;  c.by = 18'sd55706;  c.cy = 18'sd104858;
            end
            MAP_LEFT: begin
                c.ax = 18'sd13107;  c.bx = -18'sd17039; c.cx = 18'sd0;
                c.ay = 18'sd15073;  c.by = 18'sd14418;  c.cy = 18'sd104858;
            end
            default: begin
                c.ax = -18'sd9830;  c.bx = 18'sd18350;  c.cx = 18'sd0;
                c.ay = 18'sd17039;  c.by = 18'sd15729;  c.cy = 18'sd28836;
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/fern_ifs_step_core.sv]
// Barnsley fern IFS step core: one affine map step and pixel plot per input beat.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  in      | sink      | i_in_valid / o_in_ready  | i_in_data  (t_in_beat)
//  out     | source    | o_out_valid / i_out_ready| o_out_data (t_out_beat)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready| i_cfg_data (canvas size)
//
// A beat is accepted only in the idle state, so no new beat is taken until the
// last one has been loaded to the output register. The core has a single
// 32x30 signed multiplier, which runs 8 products per point
// (4 affine products, 2 scalings by canvas size, 2 reciprocal divides by 11).
// Synchronous active-low reset clears the point to the origin and the canvas
// size to 400. A stalled output holds in its register; the next input beat
// is still accepted and computed, and waits in the final state for the slot.
// Config writes are always taken.
`include "fern_ifs_step_core_defines.svh"

module fern_ifs_step_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  fifs_pkg::t_in_beat        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output fifs_pkg::t_out_beat       o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [fifs_pkg::SIZE_W-1:0] i_cfg_data
);

    // Sequencer: each state issues at most one product, and consumes the
    // product issued by the state before it.
    typedef enum logic [3:0] {
        S_IDLE,  // wait for input beat
        S_AX,    // issue ax*x
        S_BX,    // accx = cx + ax*x ; issue bx*y
        S_AY,    // accx += bx*y     ; issue ay*x
        S_BY,    // accy = cy + ay*x ; issue by*y ; x' = round(accx)
        S_SX,    // accy += by*y     ; issue x'*size
        S_RY,    // y' = round(accy) ; |x'*size| >> 16
        S_DX,    // issue y'*size
        S_DY,    // |y'*size| >> 16  ; issue divx * recip(11)
        S_QX,    // qx               ; issue divy * recip(11)
        S_QY,    // qy
        S_FIN    // form pixel, load output register
    } t_state;

    localparam int ACC_W = 52;
    localparam int MA_W  = 32;
    localparam int MB_W  = 30;
    localparam int PR_W  = MA_W + MB_W;
    localparam int DIV_W = 27;
    localparam int Q_W   = 24;
    localparam int PX_W  = 26;

    t_state                     r_state;
    logic [fifs_pkg::SIZE_W-1:0] r_size;
    logic signed [31:0]         r_x;
    logic signed [31:0]         r_y;
    fifs_pkg::t_map             r_map;
    logic signed [ACC_W-1:0]    r_accx;
    logic signed [ACC_W-1:0]    r_accy;
    logic signed [PR_W-1:0]     r_prod;
    logic [DIV_W-1:0]           r_divx;
    logic [DIV_W-1:0]           r_divy;
    logic                       r_negx;
    logic                       r_negy;
    logic [Q_W-1:0]             r_qx;
    logic [Q_W-1:0]             r_qy;
    fifs_pkg::t_out_beat        r_out;
    logic                       r_out_valid;

    fifs_pkg::t_coef            coef;
    logic signed [MA_W-1:0]     n_mul_a;
    logic signed [MB_W-1:0]     n_mul_b;
    logic signed [PR_W-1:0]     n_prod;
    logic signed [ACC_W-1:0]    prod_acc;
    logic signed [ACC_W-1:0]    off_x;
    logic signed [ACC_W-1:0]    off_y;
    logic signed [31:0]         n_x_rnd;
    logic signed [31:0]         n_y_rnd;
    logic [PR_W-1:0]            prod_mag;
    logic [DIV_W-1:0]           n_div;
    logic signed [PX_W-1:0]     sx;
    logic signed [PX_W-1:0]     sy;
    logic signed [PX_W-1:0]     col;
    logic signed [PX_W-1:0]     row;
    fifs_pkg::t_out_beat        n_out;
    logic                       in_fire;
    logic                       out_free;

    // Round to nearest, ties up, to Q16, then saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]  t;
        logic signed [ACC_W-17:0] q;
        t = v + ACC_W'(32768);
        q = t[ACC_W-1:16];
        if (q[ACC_W-17:31] == '0 || q[ACC_W-17:31] == '1) begin
            return q[31:0];
        end else if (q[ACC_W-17]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    function automatic logic [11:0] clamp12(input logic signed [PX_W-1:0] v);
        if (v < 0) begin
            return 12'd0;
        end else if (v > PX_W'(4095)) begin
            return 12'd4095;
        end else begin
            return v[11:0];
        end
    endfunction

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign coef = fifs_pkg::map_coef(r_map);

    // Shared multiplier operand select
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        unique case (r_state)
            S_AX: begin
                n_mul_a = r_x;
                n_mul_b = MB_W'(coef.ax);
            end
            S_BX: begin
                n_mul_a = r_y;
                n_mul_b = MB_W'(coef.bx);
            end
            S_AY: begin
                n_mul_a = r_x;
                n_mul_b = MB_W'(coef.ay);
            end
            S_BY: begin
                n_mul_a = r_y;
                n_mul_b = MB_W'(coef.by);
            end
            S_SX: begin
                n_mul_a = r_x;
                n_mul_b = $signed({{(MB_W-fifs_pkg::SIZE_W){1'b0}}, r_size});
            end
            S_DX: begin
                n_mul_a = r_y;
                n_mul_b = $signed({{(MB_W-fifs_pkg::SIZE_W){1'b0}}, r_size});
            end
            S_DY: begin
                n_mul_a = $signed({{(MA_W-DIV_W){1'b0}}, r_divx});
                n_mul_b = $signed({1'b0, fifs_pkg::RECIP_11});
            end
            S_QX: begin
                n_mul_a = $signed({{(MA_W-DIV_W){1'b0}}, r_divy});
                n_mul_b = $signed({1'b0, fifs_pkg::RECIP_11});
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    assign n_prod   = n_mul_a * n_mul_b;
    assign prod_acc = r_prod[ACC_W-1:0];

    // Offsets in Q32 accumulator scale
    assign off_x = $signed({{(ACC_W-fifs_pkg::COEF_W-16){coef.cx[fifs_pkg::COEF_W-1]}},
                            coef.cx, 16'b0});
    assign off_y = $signed({{(ACC_W-fifs_pkg::COEF_W-16){coef.cy[fifs_pkg::COEF_W-1]}},
                            coef.cy, 16'b0});

    assign n_x_rnd = round_sat(r_accx);
    assign n_y_rnd = round_sat(r_accy);

    // |coord*size| / 65536; the floor of that by 11 is the truncated scale
    assign prod_mag = r_prod[PR_W-1] ? PR_W'(-r_prod) : PR_W'(r_prod);
    assign n_div    = prod_mag[DIV_W+15:16];

    // Pixel formation
    always_comb begin
        sx = r_negx ? -$signed({2'b0, r_qx}) : $signed({2'b0, r_qx});
        sy = r_negy ? -$signed({2'b0, r_qy}) : $signed({2'b0, r_qy});
        col = $signed({{(PX_W-fifs_pkg::SIZE_W+1){1'b0}}, r_size[fifs_pkg::SIZE_W-1:1]}) + sx;
        row = $signed({{(PX_W-fifs_pkg::SIZE_W){1'b0}}, r_size}) - sy;
        n_out.pixel_col = clamp12(col);
        n_out.pixel_row = clamp12(row);
        n_out.on_canvas = (col >= 0) && (row >= 0)
                       && (col < $signed({{(PX_W-fifs_pkg::SIZE_W){1'b0}}, r_size}))
                       && (row < $signed({{(PX_W-fifs_pkg::SIZE_W){1'b0}}, r_size}));
        n_out.map_used  = r_map;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= fifs_pkg::CANVAS_RESET;
            r_x         <= '0;
            r_y         <= '0;
            r_map       <= fifs_pkg::MAP_STEM;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            // a finishing beat reloads the slot in S_FIN instead
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_map <= fifs_pkg::pick_map(i_in_data.random_fraction);
                        if (i_in_data.restart) begin
                            r_x <= '0;
                            r_y <= '0;
                        end
                        r_state <= S_AX;
                    end
                end
                S_AX: begin
                    r_state <= S_BX;
                end
                S_BX: begin
                    r_accx  <= off_x + prod_acc;
                    r_state <= S_AY;
                end
                S_AY: begin
                    r_accx  <= r_accx + prod_acc;
                    r_state <= S_BY;
                end
                S_BY: begin
                    r_accy  <= off_y + prod_acc;
                    r_x     <= n_x_rnd;
                    r_state <= S_SX;
                end
                S_SX: begin
                    r_accy  <= r_accy + prod_acc;
                    r_state <= S_RY;
                end
                S_RY: begin
                    r_y     <= n_y_rnd;
                    r_divx  <= n_div;
                    r_negx  <= r_prod[PR_W-1];
                    r_state <= S_DX;
                end
                S_DX: begin
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_divy  <= n_div;
                    r_negy  <= r_prod[PR_W-1];
                    r_state <= S_QX;
                end
                S_QX: begin
                    r_qx    <= r_prod[Q_W+31:32];
                    r_state <= S_QY;
                end
                S_QY: begin
                    r_qy    <= r_prod[Q_W+31:32];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FIFS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, in_fire && i_in_data.restart, r_x == 32'sd0 && r_y == 32'sd0, "restart did not clear the point")
    `FIFS_ASSERT_NEXT(a_stem_x_zero, i_clk, i_rst_n, r_state == S_BY && r_map == fifs_pkg::MAP_STEM, r_x == 32'sd0, "stem map left x nonzero")
    `FIFS_ASSERT_NEXT(a_fin_delivers, i_clk, i_rst_n, r_state == S_FIN && out_free, r_out_valid && r_state == S_IDLE, "finished beat not loaded to output")
    `FIFS_ASSERT_NOW(a_on_canvas_bound, i_clk, i_rst_n, r_out_valid && r_out.on_canvas, r_out.pixel_col != 12'd4095 && r_out.pixel_row != 12'd4095, "on-canvas pixel at clamp limit")

endmodule
